### hw/rtl/start_stop_character_receiver_top_assert.svh
// ---------------------------------------------------------------------------
// Start-stop receiver assertion macros
// Shared concurrent assertion forms for the receiver modules.
// ---------------------------------------------------------------------------
`ifndef START_STOP_CHARACTER_RECEIVER_TOP_ASSERT_SVH
`define START_STOP_CHARACTER_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define SSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssr assertion failed");

// next-cycle implication
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssr assertion failed");

`endif

### hw/rtl/ssr_pkg.sv
// ---------------------------------------------------------------------------
// Start-stop receiver package
// Widths, codes, types and helper functions shared by the receiver.
// ---------------------------------------------------------------------------
package ssr_pkg;

   localparam int PERIOD_W       = 11;
   localparam int BITS_W         = 4;
   localparam int PMODE_W        = 3;
   localparam int IDX_W          = 4;
   localparam int SHIFT_W        = 9;
   localparam int CODE_W         = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 16;

   localparam logic [PERIOD_W-1:0] MIN_BIT_PERIOD = 11'd2;
   localparam logic [PERIOD_W-1:0] MAX_BIT_PERIOD = 11'd1024;
   localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 11'd176;
   localparam logic [BITS_W-1:0]   MIN_DATA_BITS  = 4'd5;
   localparam logic [BITS_W-1:0]   MAX_DATA_BITS  = 4'd8;
   localparam logic [IDX_W-1:0]    IDX_LIMIT      = 4'd15;
   localparam logic [IDX_W-1:0]    IDX_PEAK       = 4'd9;

   localparam logic [PMODE_W-1:0] PAR_NONE = 3'd0;
   localparam logic [PMODE_W-1:0] PAR_EVEN = 3'd1;
   localparam logic [PMODE_W-1:0] PAR_ODD  = 3'd2;
   localparam logic [PMODE_W-1:0] PAR_ZERO = 3'd3;
   localparam logic [PMODE_W-1:0] PAR_ONE  = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_PERIOD  = 2'd0,
      CSR_DATA_BITS   = 2'd1,
      CSR_PARITY_MODE = 2'd2,
      CSR_MSB_FIRST   = 2'd3
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_START  = 6'b000010,
      PH_DATA   = 6'b000100,
      PH_PARITY = 6'b001000,
      PH_STOP   = 6'b010000,
      PH_GUARD  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [BITS_W-1:0]   nbits;
      logic [PMODE_W-1:0]  parity_mode;
      logic                parity_on;
      logic                msb_first;
   } cfg_type;

   typedef struct packed {
      logic              parity_error;
      logic [CODE_W-1:0] char_code;
      logic              char_valid;
      logic              sample_strobe;
   } rsp_type;

   function automatic logic [CODE_W-1:0] low_mask(input logic [BITS_W-1:0] n);
      logic [CODE_W-1:0] m;
      m = '0;
      for (int i = 0; i < CODE_W; i++) begin
         m[i] = (BITS_W'(i) < n);
      end
      return m;
   endfunction

   function automatic logic [CODE_W-1:0] bit_reverse(input logic [CODE_W-1:0] d);
      logic [CODE_W-1:0] r;
      for (int i = 0; i < CODE_W; i++) begin
         r[i] = d[CODE_W-1-i];
      end
      return r;
   endfunction

endpackage

### hw/rtl/start_stop_character_receiver_top.sv
// ---------------------------------------------------------------------------
// Start-stop character receiver
// Frames oversampled asynchronous characters from a stream of line samples.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | tdata[0] line_bit
//  rsp_     | out       | tdata[0] strobe, [1] char_valid, [9:2] code, [10] parity_error
//  csr_     | in        | index 0 period, 1 data bits, 2 parity mode, 3 msb first
//
//  One sample per cycle unless rsp_ stalls; each sample gives exactly one result transfer.
//  A sample passes through the input register, then the framer update into the
//  result register.
//  Reset is synchronous; it clears frame state and handshakes and loads default settings.
//  A stalled rsp_ side holds the result register and backs up into req_.
// ---------------------------------------------------------------------------
module start_stop_character_receiver_top import ssr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] line_bit
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] sample_strobe, [1] char_valid,
                                              // [9:2] char_code, [10] parity_error
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type res;
   logic    in_valid_ff;
   logic    in_bit_ff;
   logic    can_load;
   logic    advance;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_bit_ff <= req_tdata[0];
   end

   ssr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssr_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .advance  (advance),
      .line_bit (in_bit_ff),
      .res      (res)
   );

   ssr_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/ssr_csr.sv
// ---------------------------------------------------------------------------
// Start-stop receiver configuration registers
// Write decode, storage and range clamping of the receiver settings.
// ---------------------------------------------------------------------------
module ssr_csr import ssr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [PERIOD_W-1:0] period_ff;
   logic [BITS_W-1:0]   nbits_ff;
   logic [PMODE_W-1:0]  pmode_ff;
   logic                msb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= RST_BIT_PERIOD;
         nbits_ff  <= MIN_DATA_BITS;
         pmode_ff  <= PAR_NONE;
         msb_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_PERIOD:  period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_DATA_BITS:   nbits_ff  <= csr_wdata[BITS_W-1:0];
            CSR_PARITY_MODE: pmode_ff  <= csr_wdata[PMODE_W-1:0];
            CSR_MSB_FIRST:   msb_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (period_ff < MIN_BIT_PERIOD)      cfg.period = MIN_BIT_PERIOD;
      else if (period_ff > MAX_BIT_PERIOD) cfg.period = MAX_BIT_PERIOD;
      else                                 cfg.period = period_ff;
      if (nbits_ff < MIN_DATA_BITS)        cfg.nbits = MIN_DATA_BITS;
      else if (nbits_ff > MAX_DATA_BITS)   cfg.nbits = MAX_DATA_BITS;
      else                                 cfg.nbits = nbits_ff;
      cfg.parity_mode = pmode_ff;
      cfg.parity_on   = (pmode_ff >= PAR_EVEN) && (pmode_ff <= PAR_ONE);
      cfg.msb_first   = msb_ff;
   end

endmodule

### hw/rtl/ssr_framer.sv
// ---------------------------------------------------------------------------
// Start-stop receiver framer
// Frame state machine: one sample per advance, result computed alongside.
// ---------------------------------------------------------------------------
module ssr_framer import ssr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  logic    line_bit,
   output rsp_type res
);

`include "start_stop_character_receiver_top_assert.svh"

   phase_type           phase_ff, phase_in;
   logic [PERIOD_W-1:0] cd_ff, cd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SHIFT_W-1:0]  sh_ff, sh_in;

   logic [PERIOD_W-1:0] cd_dec;
   logic [PERIOD_W-1:0] half_period;
   logic                done;
   logic [IDX_W-1:0]    idx_put;
   logic [SHIFT_W-1:0]  sh_put;
   logic [CODE_W-1:0]   data;
   logic [CODE_W-1:0]   data_out;
   logic                pbit;
   logic                want;

   assign half_period = {1'b0, cfg.period[PERIOD_W-1:1]};
   assign cd_dec      = (cd_ff != '0) ? cd_ff - PERIOD_W'(1) : cd_ff;
   assign done        = (cd_dec == '0);
   assign idx_put     = (idx_ff < IDX_LIMIT) ? idx_ff + IDX_W'(1) : idx_ff;

   always_comb begin
      for (int i = 0; i < SHIFT_W; i++) begin
         sh_put[i] = sh_ff[i] | (line_bit && (idx_ff == IDX_W'(i)));
      end
   end

   always_comb begin
      data = sh_ff[CODE_W-1:0] & low_mask(cfg.nbits);
      pbit = sh_ff[cfg.nbits];
      case (cfg.parity_mode)
         PAR_EVEN: want = ^data;
         PAR_ODD:  want = ~(^data);
         PAR_ONE:  want = 1'b1;
         default:  want = 1'b0;
      endcase
      if (cfg.msb_first) data_out = bit_reverse(data) >> (MAX_DATA_BITS - cfg.nbits);
      else               data_out = data;
   end

   always_comb begin
      phase_in = phase_ff;
      cd_in    = cd_ff;
      idx_in   = idx_ff;
      sh_in    = sh_ff;
      res      = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!line_bit) begin
               phase_in = PH_START;
               cd_in    = half_period;
            end
         end
         PH_START: begin
            cd_in = cd_dec;
            if (done) begin
               if (!line_bit) begin
                  phase_in          = PH_DATA;
                  cd_in             = cfg.period;
                  idx_in            = '0;
                  sh_in             = '0;
                  res.sample_strobe = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_DATA: begin
            cd_in = cd_dec;
            if (done) begin
               idx_in            = idx_put;
               sh_in             = sh_put;
               cd_in             = cfg.period;
               res.sample_strobe = 1'b1;
            end
            if (idx_in >= cfg.nbits) begin
               phase_in = cfg.parity_on ? PH_PARITY : PH_STOP;
            end
         end
         PH_PARITY: begin
            cd_in = cd_dec;
            if (done) begin
               phase_in          = PH_STOP;
               idx_in            = idx_put;
               sh_in             = sh_put;
               cd_in             = cfg.period;
               res.sample_strobe = 1'b1;
            end
         end
         PH_STOP: begin
            cd_in = cd_dec;
            if (done) begin
               if (line_bit) begin
                  res.sample_strobe = 1'b1;
                  res.char_valid    = 1'b1;
                  if (cfg.parity_on && (pbit != want)) begin
                     res.parity_error = 1'b1;
                  end else begin
                     res.char_code = data_out;
                  end
               end
               phase_in = PH_GUARD;
               cd_in    = half_period;
            end
         end
         PH_GUARD: begin
            cd_in = cd_dec;
            if (done) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cd_ff    <= '0;
         idx_ff   <= '0;
         sh_ff    <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cd_ff    <= cd_in;
         idx_ff   <= idx_in;
         sh_ff    <= sh_in;
      end
   end

   `SSR_ASSERT_NOW(a_idx_bound, clock, reset, 1'b1, idx_ff <= IDX_PEAK)
   `SSR_ASSERT_NOW(a_perr_code, clock, reset, res.parity_error,
                   res.char_valid && (res.char_code == '0))
   `SSR_ASSERT_NEXT(a_char_guard, clock, reset, advance && res.char_valid,
                    phase_ff == PH_GUARD)
   `SSR_ASSERT_NEXT(a_start_clear, clock, reset,
                    advance && (phase_ff == PH_START) && res.sample_strobe,
                    (idx_ff == '0) && (sh_ff == '0) && (phase_ff == PH_DATA))

endmodule

### hw/rtl/ssr_out_reg.sv
// ---------------------------------------------------------------------------
// Start-stop receiver result register
// Holds one result transfer until the downstream side takes it.
// ---------------------------------------------------------------------------
module ssr_out_reg import ssr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rsp_type               res,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    valid_ff;
   rsp_type data_ff;

   assign can_load   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= res;
   end

endmodule
